>>> sv/lodsr_pkg.sv
`default_nettype none

package lodsr_pkg;

  localparam int RATIO_W = 8;

  localparam logic [15:0] EDGE_SAT   = 16'hFFFF;
  localparam logic [12:0] CORNER_SAT = 13'h1FFF;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SELECT = 2'd1,
    REQ_SEAM   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_NODE,
    ST_REGION
  } state_e;

  // statistics update, at most one strobe per finished word
  typedef struct packed {
    logic               clear;
    logic               seam;
    logic [2:0]         corners_old;
    logic [2:0]         corners_new;
    logic [RATIO_W-1:0] ratio;
  } stat_upd_t;

  // stitched perpendicular side pairs of a mask
  function automatic logic [2:0] corners_of(input logic [3:0] m);
    logic [1:0] h;
    logic [1:0] v;
    h = {1'b0, m[0]} + {1'b0, m[1]};
    v = {1'b0, m[2]} + {1'b0, m[3]};
    return 3'(h) * 3'(v);
  endfunction

endpackage

`default_nettype wire

>>> sv/lodsr_stats.sv
`default_nettype none

module lodsr_stats (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lodsr_pkg::stat_upd_t        upd_i,
  output logic [15:0]                      edge_total_o,
  output logic [lodsr_pkg::RATIO_W-1:0]    max_ratio_o,
  output logic [12:0]                      corner_total_o
);

  logic [15:0]                   edge_q, edge_d;
  logic [lodsr_pkg::RATIO_W-1:0] max_q, max_d;
  logic [12:0]                   corner_q, corner_d;
  logic [13:0]                   csum;

  always_comb begin
    edge_d   = edge_q;
    max_d    = max_q;
    corner_d = corner_q;
    // on a seam the corner count only grows: a seam never removes a side bit
    csum = {1'b0, corner_q} + 14'(upd_i.corners_new) - 14'(upd_i.corners_old);
    if (upd_i.clear) begin
      edge_d   = '0;
      max_d    = lodsr_pkg::RATIO_W'(1);
      corner_d = '0;
    end else if (upd_i.seam) begin
      if (edge_q != lodsr_pkg::EDGE_SAT) begin
        edge_d = edge_q + 16'd1;
      end
      if (upd_i.ratio > max_q) begin
        max_d = upd_i.ratio;
      end
      corner_d = (csum > {1'b0, lodsr_pkg::CORNER_SAT}) ? lodsr_pkg::CORNER_SAT : csum[12:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= '0;
      max_q    <= lodsr_pkg::RATIO_W'(1);
      corner_q <= '0;
    end else begin
      edge_q   <= edge_d;
      max_q    <= max_d;
      corner_q <= corner_d;
    end
  end

  assign edge_total_o   = edge_q;
  assign max_ratio_o    = max_q;
  assign corner_total_o = corner_q;

endmodule

`default_nettype wire

>>> sv/lod_seam_region_table.sv
`default_nettype none

// Seam region table. Each word is one request: clear, select a node, add a
// seam on a selected node, or look up a node; each gives exactly one result
// word carrying the node's region (slot, side mask, per-side max ratio) and
// the running statistics. Each item first reads the node map memory, then
// reads the region store memory and writes it back; the next word is
// taken in the cycle its predecessor's result is loaded, except after a
// clear word. After reset and after every clear word the node map is
// swept one entry per cycle over all min(NODE_COUNT, 1024) entries, with
// in_stall_o held high.
module lod_seam_region_table #(
  parameter int NODE_COUNT = 1024,
  parameter int RATIO_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [9:0]  node_index_i,
  input  wire logic [1:0]  side_i,
  input  wire logic [7:0]  stitch_ratio_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             found_o,
  output logic [9:0]       region_slot_o,
  output logic [3:0]       edge_mask_o,
  output logic [7:0]       west_ratio_o,
  output logic [7:0]       east_ratio_o,
  output logic [7:0]       south_ratio_o,
  output logic [7:0]       north_ratio_o,
  output logic [15:0]      edge_total_o,
  output logic [7:0]       max_ratio_seen_o,
  output logic [10:0]      region_total_o,
  output logic [12:0]      corner_total_o,
  output logic             seam_applied_o
);

  localparam int MapDepth = (NODE_COUNT < 1024) ? NODE_COUNT : 1024;
  localparam int IdxW     = $clog2(MapDepth);
  localparam int CntW     = $clog2(MapDepth + 1);
  localparam int RatW     = (RATIO_BITS < 8) ? RATIO_BITS : 8;
  localparam int EntW     = 4 + 4 * RatW;
  localparam int NodeW    = IdxW + 2;

  lodsr_pkg::state_e state_q, state_d;
  logic              finish;
  logic              accept;

  logic [IdxW-1:0]   sweep_cnt_q;
  logic [CntW-1:0]   region_count_q, region_count_d;

  // item registers
  lodsr_pkg::req_e   req_q;
  logic [IdxW-1:0]   node_q;
  logic [1:0]        side_q;
  logic [RatW-1:0]   ratio_q;
  logic              in_range_q;

  // node stage results
  logic              st_found_q, st_new_q, st_apply_q;
  logic [IdxW-1:0]   st_slot_q;
  logic              nd_sel, nd_vld;
  logic [IdxW-1:0]   nd_slot;
  logic              apply_d, new_d, found_d;
  logic [IdxW-1:0]   slot_d;

  // memories: node map entry is {selected, region valid, slot}
  logic [NodeW-1:0]  node_mem [MapDepth];
  logic [NodeW-1:0]  node_rd_q;
  logic              node_we;
  logic [IdxW-1:0]   node_waddr;
  logic [NodeW-1:0]  node_wdata;

  logic [EntW-1:0]   rg_mem [MapDepth];
  logic [EntW-1:0]   rg_rd_q;
  logic [EntW-1:0]   rg_base, rg_mod;
  logic              rg_we;
  logic [RatW-1:0]   eff_ratio;
  logic [RatW-1:0]   cur_ratio;

  // result word
  logic              out_valid_q;
  logic              out_found_q;
  logic [IdxW-1:0]   out_slot_q;
  logic [3:0]        out_mask_q;
  logic [RatW-1:0]   out_ratio_q [4];
  logic              out_applied_q;

  lodsr_pkg::stat_upd_t           upd;
  logic [lodsr_pkg::RATIO_W-1:0]  max_ratio;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= lodsr_pkg::ST_SWEEP;
      sweep_cnt_q    <= '0;
      region_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      region_count_q <= region_count_d;
      if (state_q == lodsr_pkg::ST_SWEEP) begin
        sweep_cnt_q <= (sweep_cnt_q == IdxW'(MapDepth - 1)) ? '0 : sweep_cnt_q + IdxW'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    finish     = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lodsr_pkg::ST_SWEEP: begin
        if (sweep_cnt_q == IdxW'(MapDepth - 1)) begin
          state_d = lodsr_pkg::ST_IDLE;
        end
      end
      lodsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = lodsr_pkg::ST_NODE;
        end
      end
      lodsr_pkg::ST_NODE: begin
        state_d = lodsr_pkg::ST_REGION;
      end
      lodsr_pkg::ST_REGION: begin
        if (!out_valid_q || !out_stall_i) begin
          finish = 1'b1;
          if (req_q == lodsr_pkg::REQ_CLEAR) begin
            state_d = lodsr_pkg::ST_SWEEP;
          end else begin
            in_stall_o = 1'b0;
            state_d    = in_valid_i ? lodsr_pkg::ST_NODE : lodsr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lodsr_pkg::ST_SWEEP;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    region_count_d = region_count_q;
    if (finish && req_q == lodsr_pkg::REQ_CLEAR) begin
      region_count_d = '0;
    end else if (finish && st_new_q) begin
      region_count_d = region_count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= lodsr_pkg::req_e'(req_type_i);
      node_q     <= node_index_i[IdxW-1:0];
      side_q     <= side_i;
      ratio_q    <= stitch_ratio_i[RatW-1:0];
      in_range_q <= ({22'd0, node_index_i} < 32'(NODE_COUNT));
    end
  end

  // ------------------------------------------------------- node map stage
  always_comb begin
    nd_sel  = node_rd_q[NodeW-1];
    nd_vld  = node_rd_q[NodeW-2];
    nd_slot = node_rd_q[IdxW-1:0];
    apply_d = in_range_q && nd_sel && (req_q == lodsr_pkg::REQ_SEAM);
    new_d   = apply_d && !nd_vld;
    found_d = in_range_q && (nd_vld || apply_d) && (req_q != lodsr_pkg::REQ_CLEAR);
    // a new region takes the next slot in insertion order
    slot_d  = nd_vld ? nd_slot : region_count_q[IdxW-1:0];

    node_we    = 1'b0;
    node_waddr = sweep_cnt_q;
    node_wdata = '0;
    if (state_q == lodsr_pkg::ST_SWEEP) begin
      node_we = 1'b1;
    end else if (state_q == lodsr_pkg::ST_NODE && in_range_q &&
                 (req_q == lodsr_pkg::REQ_SELECT || new_d)) begin
      node_we    = 1'b1;
      node_waddr = node_q;
      node_wdata = {1'b1, nd_vld || new_d, slot_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (accept) begin
      node_rd_q <= node_mem[node_index_i[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lodsr_pkg::ST_NODE) begin
      st_found_q <= found_d;
      st_new_q   <= new_d;
      st_apply_q <= apply_d;
      st_slot_q  <= slot_d;
    end
  end

  // ---------------------------------------------------- region store stage
  always_comb begin
    rg_base   = st_new_q ? '0 : rg_rd_q;
    rg_mod    = rg_base;
    eff_ratio = (ratio_q == '0) ? RatW'(1) : ratio_q;
    cur_ratio = '0;
    for (int s = 0; s < 4; s++) begin
      if (side_q == 2'(s)) begin
        cur_ratio = rg_base[4 + s * RatW +: RatW];
      end
    end
    if (st_apply_q) begin
      for (int s = 0; s < 4; s++) begin
        if (side_q == 2'(s)) begin
          rg_mod[s] = 1'b1;
          if (eff_ratio > cur_ratio) begin
            rg_mod[4 + s * RatW +: RatW] = eff_ratio;
          end
        end
      end
    end
    rg_we = finish && st_apply_q;
  end

  always_ff @(posedge clk_i) begin
    if (rg_we) begin
      rg_mem[st_slot_q] <= rg_mod;
    end
    if (state_q == lodsr_pkg::ST_NODE) begin
      rg_rd_q <= rg_mem[nd_slot];
    end
  end

  // ------------------------------------------------------------ statistics
  always_comb begin
    upd.clear       = finish && (req_q == lodsr_pkg::REQ_CLEAR);
    upd.seam        = finish && st_apply_q;
    upd.corners_old = lodsr_pkg::corners_of(rg_base[3:0]);
    upd.corners_new = lodsr_pkg::corners_of(rg_mod[3:0]);
    upd.ratio       = lodsr_pkg::RATIO_W'(ratio_q);
  end

  lodsr_stats u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (upd),
    .edge_total_o   (edge_total_o),
    .max_ratio_o    (max_ratio),
    .corner_total_o (corner_total_o)
  );

  // ------------------------------------------------------------ result word
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_found_q   <= st_found_q;
      out_slot_q    <= st_found_q ? st_slot_q : '0;
      out_mask_q    <= st_found_q ? rg_mod[3:0] : 4'd0;
      out_applied_q <= st_apply_q;
      for (int s = 0; s < 4; s++) begin
        out_ratio_q[s] <= st_found_q ? rg_mod[4 + s * RatW +: RatW] : '0;
      end
    end
  end

  // statistics registers only move when a new result word is loaded
  assign out_valid_o      = out_valid_q;
  assign found_o          = out_found_q;
  assign region_slot_o    = 10'(out_slot_q);
  assign edge_mask_o      = out_mask_q;
  assign west_ratio_o     = 8'(out_ratio_q[0]);
  assign east_ratio_o     = 8'(out_ratio_q[1]);
  assign south_ratio_o    = 8'(out_ratio_q[2]);
  assign north_ratio_o    = 8'(out_ratio_q[3]);
  assign max_ratio_seen_o = max_ratio;
  assign region_total_o   = 11'(region_count_q);
  assign seam_applied_o   = out_applied_q;

`ifndef SYNTHESIS
  a_accept_to_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == lodsr_pkg::ST_NODE)
    else $error("accepted word did not start a node map read");

  a_sweep_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lodsr_pkg::ST_SWEEP |-> in_stall_o)
    else $error("word taken during node map sweep");

  a_applied_has_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!seam_applied_o || (found_o && edge_mask_o != 4'd0)))
    else $error("applied seam without a stitched region");

  a_region_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    region_count_q <= CntW'(MapDepth))
    else $error("region count beyond table depth");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o)
    else $error("finished word not presented");
`endif

endmodule

`default_nettype wire

>>> bench/lod_seam_region_checker.sv
`default_nettype none

module lod_seam_region_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [9:0]  node_index_i,
  input  wire logic [1:0]  side_i,
  input  wire logic [7:0]  stitch_ratio_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic        found_i,
  input  wire logic [9:0]  region_slot_i,
  input  wire logic [3:0]  edge_mask_i,
  input  wire logic [7:0]  west_ratio_i,
  input  wire logic [7:0]  east_ratio_i,
  input  wire logic [7:0]  south_ratio_i,
  input  wire logic [7:0]  north_ratio_i,
  input  wire logic [15:0] edge_total_i,
  input  wire logic [7:0]  max_ratio_seen_i,
  input  wire logic [10:0] region_total_i,
  input  wire logic [12:0] corner_total_i,
  input  wire logic        seam_applied_i,
  output int               fail_count_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = 1024;
  localparam int EDGE_MAX    = 65535;
  localparam int CORNER_MAX  = 8191;
  localparam int REGION_MAX  = 2047;

  typedef struct packed {
    logic        found;
    logic [9:0]  slot;
    logic [3:0]  mask;
    logic [7:0]  west;
    logic [7:0]  east;
    logic [7:0]  south;
    logic [7:0]  north;
    logic [15:0] edges;
    logic [7:0]  max_ratio;
    logic [10:0] regions;
    logic [12:0] corners;
    logic        applied;
  } region_report_t;

  // shadow of the seam tables
  bit          node_selected [NODES];
  bit          node_has_region [NODES];
  logic [9:0]  node_slot [NODES];
  logic [3:0]  slot_mask [NODES];
  logic [7:0]  slot_ratio [NODES][4];
  int          region_cnt;
  int          edge_cnt;
  int          ratio_peak;
  int          corner_cnt;

  region_report_t region_reports_q[$];
  int             mismatches;

  assign fail_count_o = mismatches;

  function automatic int perp_pairs(logic [3:0] m);
    return (int'(m[0]) + int'(m[1])) * (int'(m[2]) + int'(m[3]));
  endfunction

  function void wipe_tables();
    for (int i = 0; i < NODES; i++) begin
      node_selected[i]   = 1'b0;
      node_has_region[i] = 1'b0;
      node_slot[i]       = '0;
      slot_mask[i]       = '0;
      for (int s = 0; s < 4; s++) slot_ratio[i][s] = '0;
    end
    region_cnt = 0;
    edge_cnt   = 0;
    ratio_peak = 1;
    corner_cnt = 0;
  endfunction

  function automatic region_report_t apply_request(lodsr_pkg::req_e req, logic [9:0] node,
                                                   logic [1:0] side, logic [7:0] ratio);
    region_report_t rep;
    logic [9:0]     s;
    logic [7:0]     eff;
    int             old_pairs;
    rep = '0;
    case (req)
      lodsr_pkg::REQ_CLEAR: wipe_tables();
      lodsr_pkg::REQ_SELECT: node_selected[node] = 1'b1;
      lodsr_pkg::REQ_SEAM: begin
        if (node_selected[node]) begin
          if (!node_has_region[node]) begin
            node_slot[node]       = region_cnt[9:0];
            slot_mask[region_cnt] = '0;
            for (int k = 0; k < 4; k++) slot_ratio[region_cnt][k] = '0;
            node_has_region[node] = 1'b1;
            region_cnt++;
          end
          s = node_slot[node];
          old_pairs = perp_pairs(slot_mask[s]);
          slot_mask[s] = slot_mask[s] | (4'b0001 << side);
          eff = (ratio == 8'd0) ? 8'd1 : ratio;
          if (eff > slot_ratio[s][side]) slot_ratio[s][side] = eff;
          corner_cnt += perp_pairs(slot_mask[s]) - old_pairs;
          if (corner_cnt > CORNER_MAX) corner_cnt = CORNER_MAX;
          if (edge_cnt < EDGE_MAX) edge_cnt++;
          if (int'(ratio) > ratio_peak) ratio_peak = int'(ratio);
          rep.applied = 1'b1;
        end
      end
      default: ;
    endcase
    if (req != lodsr_pkg::REQ_CLEAR && node_has_region[node]) begin
      s = node_slot[node];
      rep.found = 1'b1;
      rep.slot  = s;
      rep.mask  = slot_mask[s];
      rep.west  = slot_ratio[s][0];
      rep.east  = slot_ratio[s][1];
      rep.south = slot_ratio[s][2];
      rep.north = slot_ratio[s][3];
    end
    rep.edges     = 16'(edge_cnt);
    rep.max_ratio = 8'(ratio_peak);
    rep.regions   = 11'((region_cnt > REGION_MAX) ? REGION_MAX : region_cnt);
    rep.corners   = 13'(corner_cnt);
    return rep;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    region_report_t want;
    if (!rst_ni) begin
      wipe_tables();
      region_reports_q.delete();
      pending_o <= 0;
    end else begin
      // results always trail their word, so pop first
      if (out_valid_i && !out_stall_i) begin
        if (region_reports_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          mismatches++;
        end else begin
          want = region_reports_q.pop_front();
          check_field("found", 16'(want.found), 16'(found_i));
          check_field("region_slot", 16'(want.slot), 16'(region_slot_i));
          check_field("edge_mask", 16'(want.mask), 16'(edge_mask_i));
          check_field("west_ratio", 16'(want.west), 16'(west_ratio_i));
          check_field("east_ratio", 16'(want.east), 16'(east_ratio_i));
          check_field("south_ratio", 16'(want.south), 16'(south_ratio_i));
          check_field("north_ratio", 16'(want.north), 16'(north_ratio_i));
          check_field("edge_total", want.edges, edge_total_i);
          check_field("max_ratio_seen", 16'(want.max_ratio), 16'(max_ratio_seen_i));
          check_field("region_total", 16'(want.regions), 16'(region_total_i));
          check_field("corner_total", 16'(want.corners), 16'(corner_total_i));
          check_field("seam_applied", 16'(want.applied), 16'(seam_applied_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        region_reports_q.insert(region_reports_q.size(),
                                apply_request(lodsr_pkg::req_e'(req_type_i), node_index_i,
                                              side_i, stitch_ratio_i));
      end
      pending_o <= region_reports_q.size();
    end
  end

endmodule

`default_nettype wire

>>> bench/lod_seam_region_table_tb.sv
`default_nettype none

module lod_seam_region_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET = 1600;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [1:0] SIDE_WEST  = 2'd0;
  localparam logic [1:0] SIDE_EAST  = 2'd1;
  localparam logic [1:0] SIDE_SOUTH = 2'd2;
  localparam logic [1:0] SIDE_NORTH = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [9:0]  node_index_i;
  logic [1:0]  side_i;
  logic [7:0]  stitch_ratio_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        found_o;
  logic [9:0]  region_slot_o;
  logic [3:0]  edge_mask_o;
  logic [7:0]  west_ratio_o;
  logic [7:0]  east_ratio_o;
  logic [7:0]  south_ratio_o;
  logic [7:0]  north_ratio_o;
  logic [15:0] edge_total_o;
  logic [7:0]  max_ratio_seen_o;
  logic [10:0] region_total_o;
  logic [12:0] corner_total_o;
  logic        seam_applied_o;

  int fail_count;
  int pending_words;
  int words_sent;
  int idle_cycles;
  int hold_len;
  bit calm;

  lod_seam_region_table uut (.*);

  lod_seam_region_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .node_index_i    (node_index_i),
    .side_i          (side_i),
    .stitch_ratio_i  (stitch_ratio_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_i         (found_o),
    .region_slot_i   (region_slot_o),
    .edge_mask_i     (edge_mask_o),
    .west_ratio_i    (west_ratio_o),
    .east_ratio_i    (east_ratio_o),
    .south_ratio_i   (south_ratio_o),
    .north_ratio_i   (north_ratio_o),
    .edge_total_i    (edge_total_o),
    .max_ratio_seen_i(max_ratio_seen_o),
    .region_total_i  (region_total_o),
    .corner_total_i  (corner_total_o),
    .seam_applied_i  (seam_applied_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog: cycles in which neither channel moves a word
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stall per word, plus the long hold-off when asked
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      n = hold_len + (calm ? 0 : $urandom_range(0, 4));
      hold_len = 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [7:0] pick_ratio();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input lodsr_pkg::req_e req, input logic [9:0] node,
                           input logic [1:0] side, input logic [7:0] ratio);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    node_index_i   <= node;
    side_i         <= side;
    stitch_ratio_i <= ratio;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  initial begin
    logic [9:0] pool [24];
    int         pool_n;
    int         phase_no;
    int         steps;
    int         k;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = lodsr_pkg::REQ_CLEAR;
    node_index_i   = '0;
    side_i         = SIDE_WEST;
    stitch_ratio_i = '0;
    words_sent     = 0;
    hold_len       = 0;
    calm           = 1'b0;
    phase_no       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners of the behavior
    send_word(lodsr_pkg::REQ_LOOKUP, 10'd0, SIDE_WEST, 8'd0);
    send_word(lodsr_pkg::REQ_SEAM, 10'd5, SIDE_NORTH, 8'd9);      // node never selected
    send_word(lodsr_pkg::REQ_SELECT, 10'd0, SIDE_EAST, 8'd255);
    send_word(lodsr_pkg::REQ_SELECT, 10'd1023, SIDE_SOUTH, 8'd0);
    send_word(lodsr_pkg::REQ_SELECT, 10'd5, SIDE_NORTH, 8'd17);
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_WEST, 8'd0);       // zero ratio counts as one
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_EAST, 8'd255);
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_SOUTH, 8'd3);
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_NORTH, 8'd128);
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_WEST, 8'd7);
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_WEST, 8'd2);       // lower ratio keeps the max
    send_word(lodsr_pkg::REQ_SEAM, 10'd1023, SIDE_NORTH, 8'd1);
    send_word(lodsr_pkg::REQ_SEAM, 10'd1023, SIDE_EAST, 8'd200);
    send_word(lodsr_pkg::REQ_SEAM, 10'd5, SIDE_SOUTH, 8'd0);
    send_word(lodsr_pkg::REQ_SELECT, 10'd682, SIDE_WEST, 8'd85);
    send_word(lodsr_pkg::REQ_LOOKUP, 10'd682, SIDE_EAST, 8'd170); // selected, no region yet
    send_word(lodsr_pkg::REQ_LOOKUP, 10'd0, SIDE_NORTH, 8'd255);
    send_word(lodsr_pkg::REQ_LOOKUP, 10'd1023, SIDE_SOUTH, 8'd1);
    send_word(lodsr_pkg::REQ_SELECT, 10'd0, SIDE_WEST, 8'd0);     // reselect reports the region
    send_word(lodsr_pkg::REQ_SEAM, 10'd682, SIDE_EAST, 8'd85);
    send_word(lodsr_pkg::REQ_CLEAR, 10'd341, SIDE_NORTH, 8'd170);
    send_word(lodsr_pkg::REQ_LOOKUP, 10'd0, SIDE_WEST, 8'd0);
    send_word(lodsr_pkg::REQ_SEAM, 10'd0, SIDE_WEST, 8'd4);       // selection gone after clear
    send_word(lodsr_pkg::REQ_SELECT, 10'd341, SIDE_SOUTH, 8'd0);
    send_word(lodsr_pkg::REQ_SEAM, 10'd341, SIDE_WEST, 8'd170);

    // random phases: select a pool of nodes, then stitch and probe them
    while (words_sent < WORD_TARGET) begin
      phase_no++;
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0)
        send_word(lodsr_pkg::REQ_CLEAR, 10'($urandom), 2'($urandom), 8'($urandom));
      pool_n = $urandom_range(1, 24);
      for (int i = 0; i < pool_n; i++) pool[i] = 10'($urandom_range(0, 1023));
      for (int i = 0; i < pool_n; i++) begin
        if ($urandom_range(0, 7) != 0)
          send_word(lodsr_pkg::REQ_SELECT, pool[i], 2'($urandom), 8'($urandom));
      end
      if (phase_no == 2) hold_len = HOLD_CYCLES;
      steps = $urandom_range(20, 120);
      repeat (steps) begin
        k = $urandom_range(0, 99);
        if (k < 70)
          send_word(lodsr_pkg::REQ_SEAM, pool[$urandom_range(0, pool_n - 1)], 2'($urandom),
                    pick_ratio());
        else if (k < 82)
          send_word(lodsr_pkg::REQ_LOOKUP, pool[$urandom_range(0, pool_n - 1)], 2'($urandom),
                    8'($urandom));
        else if (k < 88)
          send_word(lodsr_pkg::REQ_SELECT, pool[$urandom_range(0, pool_n - 1)], 2'($urandom),
                    8'($urandom));
        else
          send_word(lodsr_pkg::req_e'($urandom_range(1, 3)), 10'($urandom), 2'($urandom),
                    pick_ratio());
      end
      if (phase_no == 3 || $urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
